### rtl/cnmp_pkg.sv
// Package for the calibration nearest-match position block.
// Holds request/result struct types, field widths and parameter defaults.
// No dependencies.
package cnmp_pkg;

    localparam int CHANNELS      = 8;
    localparam int POS_W         = 16;
    localparam int FIELD_W       = 16;
    localparam int ROW_IDX_W     = 8;
    localparam int ROW_COUNT_W   = 9;
    localparam int DIST_W        = 19;

    localparam int MAX_ROWS_DEF      = 256;
    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int SAMPLE_BITS_DEF   = 16;

    typedef enum logic
    {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic                        kind;
        logic [ROW_IDX_W-1:0]        row_index;
        logic signed [POS_W-1:0]     row_position;
        logic signed [FIELD_W-1:0]   level_0;
        logic signed [FIELD_W-1:0]   level_1;
        logic signed [FIELD_W-1:0]   level_2;
        logic signed [FIELD_W-1:0]   level_3;
        logic signed [FIELD_W-1:0]   level_4;
        logic signed [FIELD_W-1:0]   level_5;
        logic signed [FIELD_W-1:0]   level_6;
        logic signed [FIELD_W-1:0]   level_7;
    } request_t;

    typedef struct packed
    {
        logic signed [POS_W-1:0]     position_estimate;
        logic signed [POS_W-1:0]     average_position;
        logic [ROW_IDX_W-1:0]        best_row;
        logic [DIST_W-1:0]           best_distance;
    } result_t;

endpackage

### rtl/cnmp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data, valid in the cycle after the read; read data holds when re is low.
// No dependencies.
module cnmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/calibration_nearest_match_position.sv
// Top level of the calibration nearest-match position estimator.
// Uses cnmp_pkg (types, widths, defaults) and cnmp_ram (row table, history ring).
//
// A request is taken when start is high and busy is low. A load request
// (kind = 0) writes one calibration row in the cycle it is taken and leaves
// busy low, so loads may follow each other every cycle; it gives no result.
// A query request (kind = 1) raises busy and scans the row table, one row per
// cycle through the row RAM read port, then updates the position history and
// computes its floor mean with a reciprocal multiply. It searches N rows
// (row_count, clamped to 1..MAX_ROWS) and runs through the scan, the drain
// of the compare pipeline, the history update and the mean before the done
// strobe. busy falls in the cycle the strobe is shown, so the next request
// can be taken then. done is high for exactly one cycle; "result" holds the
// query's values from then until the next query ends, and the receiver
// cannot hold it off. The user writes row_count through cfg_we/cfg_wdata
// only while the block is idle; the block does not enforce this. Rows must
// be loaded before any query searches them.
module calibration_nearest_match_position #(
    parameter int MAX_ROWS      = cnmp_pkg::MAX_ROWS_DEF,
    parameter int HISTORY_DEPTH = cnmp_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_BITS   = cnmp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cnmp_pkg::request_t                  request,
    input  logic                                cfg_we,
    input  logic [cnmp_pkg::ROW_COUNT_W-1:0]    cfg_wdata,
    output logic                                done,
    output cnmp_pkg::result_t                   result
);

    localparam int CH   = cnmp_pkg::CHANNELS;
    localparam int PW   = cnmp_pkg::POS_W;
    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = $clog2(MAX_ROWS);
    localparam int CW   = (AW + 1 > cnmp_pkg::ROW_COUNT_W) ? AW + 1 : cnmp_pkg::ROW_COUNT_W;
    localparam int RW   = PW + CH * SB;
    localparam int SW   = SB + 3;                       // sum of eight SB-bit magnitudes
    localparam int HAW  = $clog2(HISTORY_DEPTH);
    localparam int WU   = PW + HAW;                     // biased history sum, unsigned
    localparam int TW   = WU + 1;                       // history sum, signed
    localparam int RS   = WU + HAW;                     // reciprocal scale
    localparam logic [RS-1:0] RECIP =
        RS'(((64'd1 << RS) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
    localparam logic signed [TW-1:0] BIAS = TW'(32768 * HISTORY_DEPTH);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_HIST,
        ST_DIV
    } state_t;

    state_t state_reg;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic                   accept;
    logic                   accept_query;
    logic                   accept_load;
    logic [SB-1:0]          req_lvl [CH];
    logic [AW+7:0]          ridx_ext;
    logic                   ridx_ok;
    logic [RW-1:0]          row_wdata;

    assign accept       = start && !busy;
    assign accept_query = accept && (request.kind == cnmp_pkg::KIND_QUERY);
    assign accept_load  = accept && (request.kind == cnmp_pkg::KIND_LOAD);

    // each level is the low SB bits of the field (zero-extended if SB > 16)
    assign req_lvl[0] = SB'($unsigned(request.level_0));
    assign req_lvl[1] = SB'($unsigned(request.level_1));
    assign req_lvl[2] = SB'($unsigned(request.level_2));
    assign req_lvl[3] = SB'($unsigned(request.level_3));
    assign req_lvl[4] = SB'($unsigned(request.level_4));
    assign req_lvl[5] = SB'($unsigned(request.level_5));
    assign req_lvl[6] = SB'($unsigned(request.level_6));
    assign req_lvl[7] = SB'($unsigned(request.level_7));

    assign ridx_ext = (AW + 8)'(request.row_index);
    assign ridx_ok  = ridx_ext < (AW + 8)'(MAX_ROWS);   // loads past the table are dropped

    always_comb
    begin
        row_wdata = '0;
        row_wdata[RW-1 -: PW] = request.row_position;
        for (int c = 0; c < CH; c++)
        begin
            row_wdata[c*SB +: SB] = req_lvl[c];
        end
    end

    // ------------------------------------------------------------------
    // Row table: position and eight levels per row, one row per word
    // ------------------------------------------------------------------
    logic                   row_we;
    logic                   row_re;
    logic [AW-1:0]          rd_addr_reg;
    logic [AW-1:0]          last_row_reg;
    logic [RW-1:0]          row_rdata;

    assign row_we = accept_load && ridx_ok;
    assign row_re = (state_reg == ST_SCAN);

    cnmp_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (ridx_ext[AW-1:0]),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (rd_addr_reg),
        .rdata (row_rdata)
    );

    // rows searched: zero counts as one, above MAX_ROWS clamps
    logic [CW-1:0]  rc_ext;
    logic [CW-1:0]  rows_lim;
    logic [CW-1:0]  last_ext;
    logic [cnmp_pkg::ROW_COUNT_W-1:0] row_count_reg;

    always_comb
    begin
        rc_ext = CW'(row_count_reg);
        if (rc_ext == '0)
        begin
            rows_lim = CW'(1);
        end
        else if (rc_ext > CW'(MAX_ROWS))
        begin
            rows_lim = CW'(MAX_ROWS);
        end
        else
        begin
            rows_lim = rc_ext;
        end
        last_ext = rows_lim - CW'(1);
    end

    // ------------------------------------------------------------------
    // History ring: reset value zero through per-entry valid bits
    // ------------------------------------------------------------------
    logic [HAW-1:0]             slot_reg;
    logic [HISTORY_DEPTH-1:0]   hvalid_reg;
    logic                       hist_we;
    logic [PW-1:0]              hist_rdata;
    logic signed [PW-1:0]       best_pos_reg;

    assign hist_we = (state_reg == ST_HIST);

    cnmp_ram #(
        .WIDTH (PW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (slot_reg),
        .wdata (best_pos_reg),
        .re    (accept_query),      // old entry fetched at query start
        .raddr (slot_reg),
        .rdata (hist_rdata)
    );

    // ------------------------------------------------------------------
    // Scan pipeline: read -> abs diffs -> sum -> compare
    // ------------------------------------------------------------------
    logic                   v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]          idx1_reg, idx2_reg, idx3_reg;
    logic signed [PW-1:0]   pos2_reg, pos3_reg;
    logic [SB-1:0]          samp_reg [CH];
    logic [SB-1:0]          absd     [CH];
    logic [SB-1:0]          absd_reg [CH];
    logic [SW-1:0]          sum_c;
    logic [SW-1:0]          sum3_reg;
    logic                   have_reg;
    logic                   take_row;
    logic [SW-1:0]          best_sum_reg;
    logic [AW-1:0]          best_idx_reg;

    always_comb
    begin
        logic [SB-1:0] rl;
        logic [SB:0]   d;
        logic [SB:0]   nd;
        for (int c = 0; c < CH; c++)
        begin
            rl      = row_rdata[c*SB +: SB];
            d       = {rl[SB-1], rl} - {samp_reg[c][SB-1], samp_reg[c]};
            nd      = -d;
            absd[c] = d[SB] ? nd[SB-1:0] : d[SB-1:0];
        end
    end

    always_comb
    begin
        sum_c = '0;
        for (int c = 0; c < CH; c++)
        begin
            sum_c = sum_c + SW'(absd_reg[c]);
        end
    end

    // first row with a strictly smaller sum wins
    assign take_row = v3_reg && (!have_reg || (sum3_reg < best_sum_reg));

    always_ff @(posedge clk)
    begin
        if (accept_query)
        begin
            for (int c = 0; c < CH; c++)
            begin
                samp_reg[c] <= req_lvl[c];
            end
        end
        idx1_reg <= rd_addr_reg;
        for (int c = 0; c < CH; c++)
        begin
            absd_reg[c] <= absd[c];
        end
        idx2_reg <= idx1_reg;
        pos2_reg <= row_rdata[RW-1 -: PW];
        sum3_reg <= sum_c;
        idx3_reg <= idx2_reg;
        pos3_reg <= pos2_reg;
        if (take_row)
        begin
            best_sum_reg <= sum3_reg;
            best_idx_reg <= idx3_reg;
            best_pos_reg <= pos3_reg;
        end
    end

    // ------------------------------------------------------------------
    // History update and floor mean: biased sum times the rounded-up
    // reciprocal of HISTORY_DEPTH, exact for every biased sum below 2^WU
    // ------------------------------------------------------------------
    logic signed [TW-1:0]   total_reg;
    logic signed [TW-1:0]   total_next;
    logic signed [PW-1:0]   old_val;
    logic signed [TW-1:0]   biased;
    logic [WU-1:0]          biased_reg;
    logic [WU+RS-1:0]       avg_prod;
    logic [PW-1:0]          avg_q;
    logic [AW+7:0]          best_idx_ext;
    logic [SW+cnmp_pkg::DIST_W-1:0] best_sum_ext;

    assign old_val    = hvalid_reg[slot_reg] ? $signed(hist_rdata) : '0;
    assign total_next = total_reg - TW'(old_val) + TW'(best_pos_reg);
    assign biased     = total_next + BIAS;         // shifts the sum into unsigned range
    // WU-bit register times a constant of about WU + 1 significant bits
    assign avg_prod   = (WU + RS)'(biased_reg) * (WU + RS)'(RECIP);
    assign avg_q      = avg_prod[RS +: PW];
    assign best_idx_ext = (AW + 8)'(best_idx_reg);
    assign best_sum_ext = (SW + cnmp_pkg::DIST_W)'(best_sum_reg);

    // ------------------------------------------------------------------
    // Control, state and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= cnmp_pkg::ROW_COUNT_W'(1);
            rd_addr_reg   <= '0;
            last_row_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            have_reg      <= 1'b0;
            slot_reg      <= '0;
            hvalid_reg    <= '0;
            total_reg     <= '0;
            biased_reg    <= '0;
            done          <= 1'b0;
            result        <= '0;
        end
        else
        begin
            done   <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (take_row)
            begin
                have_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                row_count_reg <= cfg_wdata;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_query)
                    begin
                        rd_addr_reg  <= '0;
                        last_row_reg <= last_ext[AW-1:0];
                        have_reg     <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    v1_reg <= 1'b1;
                    if (rd_addr_reg == last_row_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        rd_addr_reg <= rd_addr_reg + AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg && !v3_reg)
                    begin
                        state_reg <= ST_HIST;
                    end
                end
                ST_HIST:
                begin
                    total_reg            <= total_next;
                    hvalid_reg[slot_reg] <= 1'b1;
                    slot_reg <= (slot_reg == HAW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + HAW'(1);
                    biased_reg  <= biased[WU-1:0];
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    done                       <= 1'b1;
                    result.position_estimate   <= best_pos_reg;
                    // remove the bias: quotient minus 32768
                    result.average_position    <= $signed(avg_q ^ {1'b1, {(PW-1){1'b0}}});
                    result.best_row            <= best_idx_ext[7:0];
                    result.best_distance       <= best_sum_ext[cnmp_pkg::DIST_W-1:0];
                    state_reg                  <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DIV))
        else $error("done without a finished divide");

    a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg || v3_reg) |-> busy)
        else $error("scan pipeline active while idle");

    a_row_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(row_we && row_re))
        else $error("row table written during a scan");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept_query |=> busy && !done)
        else $error("query not held busy");

endmodule
